FILE: rtl/core/ssbr_pkg.sv
// ----------------------------------------------------------------------------
// SPI slave bus request bridge: shared package
// Item types, frame command codes and phase codes used by the bridge.
// ----------------------------------------------------------------------------
package ssbr_pkg;

    // Frame command bytes.
    localparam logic [7:0] CMD_READ  = 8'h41;
    localparam logic [7:0] CMD_WRITE = 8'h42;

    // Frame sequencer phases.
    localparam logic [1:0] PH_CMD    = 2'd0;
    localparam logic [1:0] PH_ADDR   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    // Last bit of a byte and last byte of a word.
    localparam logic [2:0] BIT_LAST  = 3'd7;
    localparam logic [1:0] BYTE_LAST = 2'd3;

    // One pin sample plus the bus side inputs of that cycle.
    typedef struct packed {
        logic        chip_select_n;
        logic        serial_clock;
        logic        serial_in;
        logic        bus_ready;
        logic        resp_valid;
        logic [31:0] resp_data;
    } ssbr_in_t;

    // Outputs produced for one sample.
    typedef struct packed {
        logic        serial_out;
        logic        req_valid_out;
        logic        req_is_write;
        logic [31:0] req_address;
        logic [31:0] req_write_data;
        logic        resp_ready_out;
    } ssbr_out_t;

endpackage

FILE: rtl/core/ssbr_core.sv
// ----------------------------------------------------------------------------
// SPI slave bus request bridge: sample processing core
// Holds the serial shifters, the frame sequencer and the pending request, and
// advances them by one step for every accepted sample item.
// ----------------------------------------------------------------------------
module ssbr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ssbr_pkg::ssbr_in_t  sample,
    output ssbr_pkg::ssbr_out_t result
);
    import ssbr_pkg::*;

    logic        prior_clock_reg, prior_clock_next;
    logic [31:0] rx_shifter_reg, rx_shifter_next;
    logic [31:0] tx_shifter_reg, tx_shifter_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [1:0]  byte_count_reg, byte_count_next;
    logic        byte_ready_reg, byte_ready_next;
    logic [1:0]  phase_reg, phase_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_write_reg, pend_write_next;
    logic [31:0] pend_address_reg, pend_address_next;
    logic [31:0] pend_data_reg, pend_data_next;

    logic        rise;
    logic        fall;
    logic        selected;
    logic [7:0]  rx_byte;

    // Edge detection against the previous sample.
    assign rise     = !prior_clock_reg && sample.serial_clock;
    assign fall     = prior_clock_reg && !sample.serial_clock;
    assign selected = !sample.chip_select_n;
    assign rx_byte  = rx_shifter_reg[7:0];

    // Result fields show the request and shifter state before this step.
    always_comb
    begin
        result.serial_out     = tx_shifter_reg[31];
        result.req_valid_out  = pend_valid_reg;
        result.req_is_write   = pend_write_reg;
        result.req_address    = pend_address_reg;
        result.req_write_data = pend_data_reg;
        result.resp_ready_out = selected && fall;
    end

    // Next state for one sample.
    always_comb
    begin
        prior_clock_next  = sample.serial_clock;
        rx_shifter_next   = rx_shifter_reg;
        tx_shifter_next   = tx_shifter_reg;
        bit_count_next    = bit_count_reg;
        byte_count_next   = byte_count_reg;
        byte_ready_next   = 1'b0;
        phase_next        = phase_reg;
        pend_valid_next   = pend_valid_reg;
        pend_write_next   = pend_write_reg;
        pend_address_next = pend_address_reg;
        pend_data_next    = pend_data_reg;

        // The bus takes the pending request.
        if (pend_valid_reg && sample.bus_ready)
        begin
            pend_valid_next = 1'b0;
        end

        // Receive side: shift on rising edges, count bits into bytes.
        if (selected && rise)
        begin
            rx_shifter_next = {rx_shifter_reg[30:0], sample.serial_in};
            bit_count_next  = bit_count_reg + 3'd1;
            byte_ready_next = (bit_count_reg == BIT_LAST);
        end
        else if (!selected)
        begin
            bit_count_next = '0;
        end

        // Transmit side: load the response or shift ones in on falling edges.
        if (selected && fall)
        begin
            if (sample.resp_valid)
            begin
                tx_shifter_next = sample.resp_data;
            end
            else
            begin
                tx_shifter_next = {tx_shifter_reg[30:0], 1'b1};
            end
        end

        // Frame sequencer works on the byte completed one step earlier.
        if (byte_ready_reg)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    byte_count_next = '0;
                    if (rx_byte == CMD_READ)
                    begin
                        phase_next      = PH_ADDR;
                        pend_write_next = 1'b0;
                    end
                    else if (rx_byte == CMD_WRITE)
                    begin
                        phase_next      = PH_ADDR;
                        pend_write_next = 1'b1;
                    end
                end
                PH_ADDR:
                begin
                    byte_count_next = byte_count_reg + 2'd1;
                    if (byte_count_reg == BYTE_LAST)
                    begin
                        byte_count_next   = '0;
                        phase_next        = PH_DATA;
                        pend_address_next = rx_shifter_reg;
                        pend_valid_next   = !pend_write_reg;
                    end
                end
                PH_DATA:
                begin
                    byte_count_next = byte_count_reg + 2'd1;
                    if (byte_count_reg == BYTE_LAST)
                    begin
                        byte_count_next = '0;
                        phase_next      = PH_CMD;
                        pend_data_next  = rx_shifter_reg;
                        pend_valid_next = pend_write_reg;
                    end
                end
                PH_UNUSED:
                begin
                    phase_next = PH_CMD;
                end
                default:
                begin
                    phase_next = PH_CMD;
                end
            endcase
        end
    end

    // State registers advance only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_clock_reg  <= 1'b0;
            rx_shifter_reg   <= '0;
            tx_shifter_reg   <= '0;
            bit_count_reg    <= '0;
            byte_count_reg   <= '0;
            byte_ready_reg   <= 1'b0;
            phase_reg        <= PH_CMD;
            pend_valid_reg   <= 1'b0;
            pend_write_reg   <= 1'b0;
            pend_address_reg <= '0;
            pend_data_reg    <= '0;
        end
        else if (advance)
        begin
            prior_clock_reg  <= prior_clock_next;
            rx_shifter_reg   <= rx_shifter_next;
            tx_shifter_reg   <= tx_shifter_next;
            bit_count_reg    <= bit_count_next;
            byte_count_reg   <= byte_count_next;
            byte_ready_reg   <= byte_ready_next;
            phase_reg        <= phase_next;
            pend_valid_reg   <= pend_valid_next;
            pend_write_reg   <= pend_write_next;
            pend_address_reg <= pend_address_next;
            pend_data_reg    <= pend_data_next;
        end
    end

endmodule

FILE: rtl/core/spi_slave_bus_request_bridge.sv
// ----------------------------------------------------------------------------
// SPI slave bus request bridge
// Turns oversampled SPI pin items into bus request and response handshake
// outputs, one result item for every sample item.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Payload
//  -------   ----------------------------------   ----------------
//  sample    sample_valid / sample_stall (out)    ssbr_in_t  item
//  result    result_valid / result_stall (in)     ssbr_out_t item
//
// One sample item is taken every cycle while sample_stall is low; its result
// item goes into the output register, or into the skid register on a stall.
// The result path has an output register and a skid register, so a sample
// is still accepted in the cycle that the result side first stalls.
// sample_stall comes from the skid register only. Reset clears the shifters,
// the sequencer and the valid flags of both result slots.
// ----------------------------------------------------------------------------
module spi_slave_bus_request_bridge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  ssbr_pkg::ssbr_in_t  sample,
    output logic                result_valid,
    input  logic                result_stall,
    output ssbr_pkg::ssbr_out_t result
);
    import ssbr_pkg::*;

    logic      accept;
    logic      take;
    ssbr_out_t step_result;

    logic      out_valid_reg;
    ssbr_out_t out_item_reg;
    logic      skid_valid_reg;
    ssbr_out_t skid_item_reg;

    // Handshake decode.
    assign sample_stall = skid_valid_reg;
    assign accept       = sample_valid && !skid_valid_reg;
    assign take         = out_valid_reg && !result_stall;

    ssbr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(accept),
        .sample (sample),
        .result (step_result)
    );

    // Output register plus skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves follow the same decisions as the valid bits.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else if (accept)
            begin
                out_item_reg <= step_result;
            end
        end
        else if (accept)
        begin
            skid_item_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
